FILE: hw/rtl/nfca_cua_pkg.sv
package nfca_cua_pkg;

   // Capacity of the UID store and the width of a count that can reach it.
   localparam int UID_MAX_BYTES = 10;
   localparam int BYTE_CNT_W    = $clog2(UID_MAX_BYTES + 1);

   localparam logic [7:0] CASCADE_TAG     = 8'h88;
   localparam logic [7:0] SAK_CASCADE_BIT = 8'h04;
   localparam logic [1:0] MAX_LEVELS      = 2'd3;

   // Bytes that one level adds to the UID.
   localparam logic [2:0] NEED_CASCADE = 3'd3;
   localparam logic [2:0] NEED_FINAL   = 3'd4;

   // Legal final UID lengths.
   localparam logic [3:0] LEN_SINGLE = 4'd4;
   localparam logic [3:0] LEN_DOUBLE = 4'd7;
   localparam logic [3:0] LEN_TRIPLE = 4'd10;

   typedef struct packed {
      logic [7:0] resp_byte0;
      logic [7:0] resp_byte1;
      logic [7:0] resp_byte2;
      logic [7:0] resp_byte3;
      logic [7:0] check_byte;
      logic [7:0] select_ack;
      logic       last_level;
   } req_item_type;

   typedef struct packed {
      logic        status;
      logic [3:0]  uid_length;
      logic [63:0] uid_low;
      logic [15:0] uid_high;
      logic [7:0]  final_sak;
   } rsp_item_type;

   typedef struct packed {
      logic [BYTE_CNT_W-1:0] byte_count;
      logic [1:0]            level_count;
   } acc_state_type;

   typedef struct packed {
      logic       cascade;
      logic       bad;
      logic [2:0] need;
   } level_chk_type;

endpackage

FILE: hw/rtl/nfca_cua_level_chk.sv
module nfca_cua_level_chk (
   input  nfca_cua_pkg::req_item_type  item,
   input  nfca_cua_pkg::acc_state_type acc_state,
   output nfca_cua_pkg::level_chk_type chk
);
   import nfca_cua_pkg::*;

   logic                  bcc_bad;
   logic                  is_cascade;
   logic                  sak_bit;
   logic                  role_bad;
   logic                  too_many;
   logic                  overflow;
   logic [2:0]            need;
   logic [BYTE_CNT_W:0]   fill_sum;

   // A cascade tag must precede further levels and announce them in the SAK;
   // any other level must close the UID with the cascade bit clear.
   always_comb begin
      bcc_bad    = (item.resp_byte0 ^ item.resp_byte1 ^ item.resp_byte2 ^ item.resp_byte3)
                   != item.check_byte;
      is_cascade = item.resp_byte0 == CASCADE_TAG;
      sak_bit    = (item.select_ack & SAK_CASCADE_BIT) != 8'd0;
      too_many   = acc_state.level_count >= MAX_LEVELS;
      if (is_cascade) begin
         role_bad = item.last_level || !sak_bit;
         need     = NEED_CASCADE;
      end else begin
         role_bad = !item.last_level || sak_bit;
         need     = NEED_FINAL;
      end
      fill_sum = {1'b0, acc_state.byte_count} + (BYTE_CNT_W + 1)'(need);
      overflow = fill_sum > (BYTE_CNT_W + 1)'(UID_MAX_BYTES);

      chk.cascade = is_cascade;
      chk.need    = need;
      chk.bad     = bcc_bad || role_bad || too_many || overflow;
   end

endmodule

FILE: hw/rtl/nfca_cua_uid_acc.sv
module nfca_cua_uid_acc (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  nfca_cua_pkg::req_item_type  item,
   input  nfca_cua_pkg::level_chk_type chk,
   output nfca_cua_pkg::acc_state_type acc_state,
   output nfca_cua_pkg::rsp_item_type  result
);
   import nfca_cua_pkg::*;

   logic [7:0]            store_ff [UID_MAX_BYTES];
   logic [7:0]            store_in [UID_MAX_BYTES];
   logic [BYTE_CNT_W-1:0] byte_count_ff;
   logic [BYTE_CNT_W-1:0] byte_count_in;
   logic [1:0]            level_count_ff;
   logic [1:0]            level_count_in;
   logic                  error_seen_ff;
   logic                  error_seen_in;
   logic                  append;
   logic                  fail;
   logic [7:0]            resp_bytes [4];

   assign resp_bytes[0] = item.resp_byte0;
   assign resp_bytes[1] = item.resp_byte1;
   assign resp_bytes[2] = item.resp_byte2;
   assign resp_bytes[3] = item.resp_byte3;

   // Each store entry picks its byte from this level when it falls inside the
   // window that starts at the current fill count.
   always_comb begin
      logic [BYTE_CNT_W-1:0] rel;
      logic [1:0]            src;
      error_seen_in = error_seen_ff || chk.bad;
      append        = !error_seen_in;
      for (int j = 0; j < UID_MAX_BYTES; j++) begin
         rel         = BYTE_CNT_W'(j) - byte_count_ff;
         src         = rel[1:0] + {1'b0, chk.cascade};
         store_in[j] = store_ff[j];
         if (append && (BYTE_CNT_W'(j) >= byte_count_ff) && (rel < BYTE_CNT_W'(chk.need))) begin
            store_in[j] = resp_bytes[src];
         end
      end
      byte_count_in  = append ? byte_count_ff + BYTE_CNT_W'(chk.need) : byte_count_ff;
      level_count_in = (level_count_ff < MAX_LEVELS) ? level_count_ff + 2'd1 : level_count_ff;

      fail = error_seen_in || !((byte_count_in == BYTE_CNT_W'(LEN_SINGLE)) ||
                                (byte_count_in == BYTE_CNT_W'(LEN_DOUBLE)) ||
                                (byte_count_in == BYTE_CNT_W'(LEN_TRIPLE)));

      result.status     = fail;
      result.uid_length = fail ? 4'd0 : 4'(byte_count_in);
      for (int i = 0; i < 8; i++) begin
         result.uid_low[8*i +: 8] = fail ? 8'd0 : store_in[i];
      end
      result.uid_high  = fail ? 16'd0 : {store_in[9], store_in[8]};
      result.final_sak = fail ? 8'd0 : item.select_ack;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last_level)) begin
         for (int j = 0; j < UID_MAX_BYTES; j++) begin
            store_ff[j] <= 8'd0;
         end
         byte_count_ff  <= '0;
         level_count_ff <= 2'd0;
         error_seen_ff  <= 1'b0;
      end else if (step) begin
         store_ff       <= store_in;
         byte_count_ff  <= byte_count_in;
         level_count_ff <= level_count_in;
         error_seen_ff  <= error_seen_in;
      end
   end

   assign acc_state.byte_count  = byte_count_ff;
   assign acc_state.level_count = level_count_ff;

endmodule

FILE: hw/rtl/nfca_cascade_uid_assembler.sv
// Channel | Direction | Handshake             | Payload
// req_    | in        | req_valid / req_ready | req_item (one cascade level)
// rsp_    | out       | rsp_valid / rsp_ready | rsp_item (assembled UID)
//
// One level is accepted per cycle while no last level waits. An accepted level
// sits in the input register, where it is checked and merged into the UID store;
// the result of a last level appears in the output register on the next edge.
// Levels that are not last never wait. A last level waits in the input register
// only while the output register holds a result that has not been taken.
// Reset is synchronous and clears the store, the counts and both valid flags.
module nfca_cascade_uid_assembler (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  nfca_cua_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output nfca_cua_pkg::rsp_item_type rsp_item
);
   import nfca_cua_pkg::*;

   logic          in_valid_ff;
   logic          in_valid_in;
   req_item_type  in_item_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_item_type  rsp_item_ff;
   rsp_item_type  result;
   acc_state_type acc_state;
   level_chk_type chk;
   logic          step;
   logic          emit;

   // The held level is processed this cycle unless it would produce a result
   // and the output register cannot take one.
   assign step      = in_valid_ff && (!in_item_ff.last_level || !rsp_valid_ff || rsp_ready);
   assign emit      = step && in_item_ff.last_level;
   assign req_ready = !in_valid_ff || step;

   nfca_cua_level_chk u_level_chk (
      .item      (in_item_ff),
      .acc_state (acc_state),
      .chk       (chk)
   );

   nfca_cua_uid_acc u_uid_acc (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (in_item_ff),
      .chk       (chk),
      .acc_state (acc_state),
      .result    (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load without reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
      if (emit) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A processed last level must leave a result in the output register.
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("last level processed but no result registered");

   // A delivered result is either malformed and zeroed, or has a legal length.
   a_rsp_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.status ?
         (rsp_item_ff.uid_length == 4'd0 && rsp_item_ff.uid_low == 64'd0) :
         (rsp_item_ff.uid_length == LEN_SINGLE || rsp_item_ff.uid_length == LEN_DOUBLE ||
          rsp_item_ff.uid_length == LEN_TRIPLE)))
      else $error("result length does not match status");

   // The accumulator starts afresh after every result.
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      emit |=> (acc_state.byte_count == '0 && acc_state.level_count == 2'd0))
      else $error("UID state not cleared after result");

   // The fill count never passes the store capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      acc_state.byte_count <= BYTE_CNT_W'(UID_MAX_BYTES))
      else $error("UID store overfilled");

endmodule
